[hdl/ghal_pkg.sv]
// Shared types and constants for the generational handle allocator.
package ghal_pkg;

  localparam int OP_W      = 2;
  localparam int OWNER_W   = 16;
  localparam int HANDLE_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int IDX_BITS  = 20;
  localparam int GEN_BITS  = HANDLE_W - IDX_BITS;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic load;    // capture request, launch memory reads
    logic commit;  // update tables, load result register
  } cmd_t;

endpackage

[hdl/ghal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ghal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[hdl/ghal_ctrl.sv]
// Controller: sequences capture and commit of one request, owns result valid.
module ghal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ghal_pkg::cmd_t    cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, commit;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign commit     = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign cmd.load   = accept;
  assign cmd.commit = commit;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/ghal_dp.sv]
// Datapath: slot table, free stack, counters and result register.
module ghal_dp #(
  parameter int SLOTS      = 1024,
  parameter int OWNER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ghal_pkg::cmd_t                    cmd,
  input  logic [ghal_pkg::OP_W-1:0]         in_op,
  input  logic [ghal_pkg::OWNER_W-1:0]      in_owner,
  input  logic [ghal_pkg::HANDLE_W-1:0]     in_handle,
  output logic [ghal_pkg::STATUS_W-1:0]     res_status,
  output logic [ghal_pkg::HANDLE_W-1:0]     res_handle,
  output logic [ghal_pkg::OWNER_W-1:0]      res_owner
);

  localparam int IW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int OW   = (OWNER_BITS < ghal_pkg::OWNER_W) ? OWNER_BITS : ghal_pkg::OWNER_W;
  localparam int GW   = ghal_pkg::GEN_BITS;
  localparam int XW   = ghal_pkg::IDX_BITS;
  localparam int SL_W = 1 + GW + OW;
  localparam int FS_W = GW + IW;

  // request registers
  logic [ghal_pkg::OP_W-1:0]     op_r;
  logic [OW-1:0]                 owner_r;
  logic [ghal_pkg::HANDLE_W-1:0] handle_r;

  // table state
  logic [CW-1:0] stk_cnt_r, stk_cnt_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;

  // memory ports
  logic            slot_we;
  logic [IW-1:0]   slot_waddr;
  logic [SL_W-1:0] slot_wdata;
  logic [SL_W-1:0] slot_rdata;
  logic            stk_we;
  logic [FS_W-1:0] stk_wdata;
  logic [FS_W-1:0] stk_rdata;
  logic [CW-1:0]   stk_dec;

  // decoded read data
  logic          sl_live;
  logic [GW-1:0] sl_gen;
  logic [OW-1:0] sl_owner;
  logic [GW-1:0] st_gen;
  logic [IW-1:0] st_idx;
  logic [GW-1:0] pop_gen;

  logic [XW-1:0] pos;
  logic [XW:0]   pos_ext, fresh_ext;
  logic          in_range;

  logic [ghal_pkg::STATUS_W-1:0] status_c;
  logic [ghal_pkg::HANDLE_W-1:0] hout_c;
  logic [ghal_pkg::OWNER_W-1:0]  oout_c;

  assign stk_dec = stk_cnt_r - CW'(1);
  assign {sl_live, sl_gen, sl_owner} = slot_rdata;
  assign {st_gen, st_idx}            = stk_rdata;
  assign pop_gen   = st_gen + GW'(1);
  assign pos       = handle_r[XW-1:0];
  assign pos_ext   = {1'b0, pos};
  assign fresh_ext = (XW + 1)'(fresh_r);
  assign in_range  = (pos != '0) && (pos_ext < fresh_ext) && sl_live;
  assign stk_wdata = {handle_r[ghal_pkg::HANDLE_W-1:XW], pos[IW-1:0]};

  ghal_ram #(.WIDTH(SL_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.load),
    .raddr (in_handle[IW-1:0]),
    .rdata (slot_rdata)
  );

  ghal_ram #(.WIDTH(FS_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_cnt_r[IW-1:0]),
    .wdata (stk_wdata),
    .re    (cmd.load),
    .raddr (stk_dec[IW-1:0]),
    .rdata (stk_rdata)
  );

  always_comb begin
    status_c    = ghal_pkg::ST_NOCHANGE;
    hout_c      = handle_r;
    oout_c      = '0;
    slot_we     = 1'b0;
    slot_waddr  = pos[IW-1:0];
    slot_wdata  = {1'b0, sl_gen, sl_owner};
    stk_we      = 1'b0;
    stk_cnt_nxt = stk_cnt_r;
    fresh_nxt   = fresh_r;
    case (op_r)
      ghal_pkg::OP_ALLOC: begin
        if (handle_r != '0) begin
          status_c = ghal_pkg::ST_NOCHANGE;
        end else if (stk_cnt_r != '0) begin
          status_c    = ghal_pkg::ST_OK;
          hout_c      = {pop_gen, XW'(st_idx)};
          slot_we     = 1'b1;
          slot_waddr  = st_idx;
          slot_wdata  = {1'b1, pop_gen, owner_r};
          stk_cnt_nxt = stk_dec;
        end else if (fresh_r < CW'(SLOTS)) begin
          status_c   = ghal_pkg::ST_OK;
          hout_c     = ghal_pkg::HANDLE_W'(fresh_r);
          slot_we    = 1'b1;
          slot_waddr = fresh_r[IW-1:0];
          slot_wdata = {1'b1, GW'(0), owner_r};
          fresh_nxt  = fresh_r + CW'(1);
        end else begin
          status_c = ghal_pkg::ST_FULL;
        end
      end
      ghal_pkg::OP_FREE: begin
        if (in_range && (sl_owner == owner_r)) begin
          status_c = ghal_pkg::ST_OK;
          slot_we  = 1'b1;
          if (stk_cnt_r < CW'(SLOTS)) begin
            stk_we      = 1'b1;
            stk_cnt_nxt = stk_cnt_r + CW'(1);
          end
        end
      end
      ghal_pkg::OP_FIND: begin
        status_c = ghal_pkg::ST_NOTFOUND;
        if (in_range && (sl_gen == handle_r[ghal_pkg::HANDLE_W-1:XW])) begin
          status_c = ghal_pkg::ST_OK;
          oout_c   = ghal_pkg::OWNER_W'(sl_owner);
        end
      end
      default: begin
        status_c = ghal_pkg::ST_NOCHANGE;
      end
    endcase
    if (!cmd.commit) begin
      slot_we     = 1'b0;
      stk_we      = 1'b0;
      stk_cnt_nxt = stk_cnt_r;
      fresh_nxt   = fresh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_cnt_r <= '0;
      fresh_r   <= CW'(1);
    end else begin
      stk_cnt_r <= stk_cnt_nxt;
      fresh_r   <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      owner_r  <= in_owner[OW-1:0];
      handle_r <= in_handle;
    end
    if (cmd.commit) begin
      res_status <= status_c;
      res_handle <= hout_c;
      res_owner  <= oout_c;
    end
  end

endmodule

[hdl/generational_handle_allocator.sv]
// Generational handle allocator top level: stream ports, controller and datapath.
// The input transfer launches the registered reads of the slot and free-stack RAMs;
// the table update and result register load follow once the output register is free.
// A new request is taken only after the current one has been committed.
// A finished result waits in the output register; a stalled output holds the update.
// Reset clears the FSM and stack count and sets the fresh-slot counter to 1; RAMs are not cleared.
module generational_handle_allocator #(
  parameter int SLOTS      = 1024,
  parameter int OWNER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] operation, [17:2] owner_tag, [49:18] handle, [55:50] zero
  input  logic [ghal_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [33:2] handle_out, [49:34] owner_out, [55:50] zero
  output logic [ghal_pkg::OUT_DATA_W-1:0] out_tdata
);

  ghal_pkg::cmd_t                  cmd;
  logic [ghal_pkg::STATUS_W-1:0]   res_status;
  logic [ghal_pkg::HANDLE_W-1:0]   res_handle;
  logic [ghal_pkg::OWNER_W-1:0]    res_owner;

  ghal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ghal_dp #(.SLOTS(SLOTS), .OWNER_BITS(OWNER_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tdata[1:0]),
    .in_owner   (in_tdata[17:2]),
    .in_handle  (in_tdata[49:18]),
    .res_status (res_status),
    .res_handle (res_handle),
    .res_owner  (res_owner)
  );

  assign out_tdata = {6'd0, res_owner, res_handle, res_status};

endmodule

[hdl/ghal_chk.sv]
// Port-level checker for the generational handle allocator, bound to the top level.
module ghal_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ghal_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in flight");

  a_owner_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ghal_pkg::ST_OK) |-> (out_tdata[49:34] == '0))
    else $error("owner reported on a failed request");

  a_ok_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ghal_pkg::ST_OK) |-> (out_tdata[33:2] != '0))
    else $error("successful result carries the null handle");

endmodule

bind generational_handle_allocator ghal_chk u_ghal_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
